/* design/bakery_ticket_arbiter_assert.svh */
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_assert.svh
// assertion macros shared by the arbiter rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BAKERY_TICKET_ARBITER_ASSERT_SVH
`define BAKERY_TICKET_ARBITER_ASSERT_SVH

// same-cycle implication
`define BTA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// shared constants, codes and types of the bakery ticket arbiter
// ----------------------------------------------------------------------------
package bta_pkg;

  // default sizes
  localparam int DEF_MAX_REQUESTERS = 8;
  localparam int DEF_TICKET_BITS    = 8;
  localparam int DEF_IDX_W          = $clog2(DEF_MAX_REQUESTERS);

  // configuration register
  localparam int             CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_INACTIVE  = 2'd2;

  // compare unit modes
  typedef enum logic {
    CMP_MAX = 1'b0,
    CMP_MIN = 1'b1
  } cmp_mode_t;

endpackage

/* design/bta_if.sv */
// ----------------------------------------------------------------------------
// bta_if
// valid/ready channels for access items and result items
// ----------------------------------------------------------------------------

// access item channel
interface bta_req_if #(
  parameter int IDX_W = bta_pkg::DEF_IDX_W
);
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [IDX_W-1:0] requester;

  modport source (output valid, output operation, output requester, input ready);
  modport sink   (input valid, input operation, input requester, output ready);
endinterface

// result item channel
interface bta_rsp_if #(
  parameter int IDX_W       = bta_pkg::DEF_IDX_W,
  parameter int TICKET_BITS = bta_pkg::DEF_TICKET_BITS
);
  logic                   valid;
  logic                   ready;
  logic [TICKET_BITS-1:0] ticket;
  logic                   may_enter;
  logic [IDX_W-1:0]       head_requester;
  logic                   head_valid;
  logic [1:0]             status;

  modport source (output valid, output ticket, output may_enter, output head_requester,
                  output head_valid, output status, input ready);
  modport sink   (input valid, input ticket, input may_enter, input head_requester,
                  input head_valid, input status, output ready);
endinterface

/* design/bakery_ticket_arbiter.sv */
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter
// request: max scan, max+1 written unless exhausted, head scan; release: valid
// bit cleared, head scan; check or inactive: head scan; one ticket read per
// cycle over the active count, items taken one at a time; a held result item
// stalls; sync active-low reset clears the ticket valid bits (all tickets zero),
// sets the active count register to 8 and empties the result register
// ----------------------------------------------------------------------------
`include "bakery_ticket_arbiter_assert.svh"

module bakery_ticket_arbiter #(
  parameter int MAX_REQUESTERS = bta_pkg::DEF_MAX_REQUESTERS,
  parameter int TICKET_BITS    = bta_pkg::DEF_TICKET_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bta_pkg::CFG_W-1:0] cfg_wdata,
  bta_req_if.sink                   in_ch,
  bta_rsp_if.source                 out_ch
);
  import bta_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTERS);
  localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAX   = 5'b00010,
    S_WRITE = 5'b00100,
    S_HEAD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    active_r;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [MAX_REQUESTERS-1:0] vld_r, vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // item and scan payload
  logic [1:0]             op_r, op_nxt;
  logic [IDX_W-1:0]       req_r, req_nxt;
  status_t                status_r, status_nxt;
  logic [TICKET_BITS-1:0] best_t_r, best_t_nxt;
  logic                   best_v_r, best_v_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [TICKET_BITS-1:0] my_t_r, my_t_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;

  // result register
  logic [TICKET_BITS-1:0] o_ticket_r, o_ticket_nxt;
  logic                   o_enter_r, o_enter_nxt;
  logic [IDX_W-1:0]       o_head_r, o_head_nxt;
  logic                   o_head_v_r, o_head_v_nxt;
  status_t                o_status_r, o_status_nxt;

  logic                   accept;
  logic [CNT_W-1:0]       n_cfg;
  logic                   inactive;
  logic                   scanning;
  logic                   issue;
  logic                   scan_done;
  logic                   out_load;
  logic [IDX_W-1:0]       rd_addr;
  logic                   ram_we;
  logic [TICKET_BITS-1:0] ram_wdata;
  logic [TICKET_BITS-1:0] ram_rdata;
  logic [TICKET_BITS-1:0] cand;
  logic                   take;
  cmp_mode_t              cmp_mode;

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = !out_valid_r || out_ch.ready;

  // active count, zero taken as one and saturated at the store depth
  always_comb begin
    if (active_r == '0) begin
      n_cfg = CNT_W'(1);
    end else if (int'(active_r) > MAX_REQUESTERS) begin
      n_cfg = CNT_W'(MAX_REQUESTERS);
    end else begin
      n_cfg = CNT_W'(active_r);
    end
  end

  assign inactive = (CNT_W'(in_ch.requester) >= n_cfg);

  // scan sequencing: one read issued per cycle, data returned in the next cycle
  assign scanning  = (state_r == S_MAX) || (state_r == S_HEAD);
  assign issue     = scanning && (issue_cnt_r < n_r);
  assign scan_done = scanning && !issue && pend_r;
  assign rd_addr   = issue_cnt_r[IDX_W-1:0];
  assign cand      = rd_vld_r ? ram_rdata : '0;
  assign cmp_mode  = (state_r == S_MAX) ? CMP_MAX : CMP_MIN;
  assign ram_wdata = best_t_r + 1'b1;

  // ticket store
  bta_ram #(
    .WIDTH (TICKET_BITS),
    .DEPTH (MAX_REQUESTERS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_r),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // shared compare unit
  bta_cmp #(
    .TICKET_BITS (TICKET_BITS)
  ) u_cmp (
    .mode   (cmp_mode),
    .cand   (cand),
    .best   (best_t_r),
    .best_v (best_v_r),
    .take   (take)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt      = issue;
    vld_nxt       = vld_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    best_t_nxt    = best_t_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    my_t_nxt      = my_t_r;
    pend_idx_nxt  = pend_idx_r;
    rd_vld_nxt    = rd_vld_r;
    ram_we        = 1'b0;
    o_ticket_nxt  = o_ticket_r;
    o_enter_nxt   = o_enter_r;
    o_head_nxt    = o_head_r;
    o_head_v_nxt  = o_head_v_r;
    o_status_nxt  = o_status_r;
    out_valid_nxt = out_valid_r;

    // read issue
    if (issue) begin
      issue_cnt_nxt = issue_cnt_r + 1'b1;
      rd_vld_nxt    = vld_r[rd_addr];
      pend_idx_nxt  = rd_addr;
    end

    // accumulate the returning ticket
    if (pend_r && take) begin
      best_t_nxt = cand;
      if (state_r == S_HEAD) begin
        best_v_nxt   = 1'b1;
        best_idx_nxt = pend_idx_r;
      end
    end
    if (pend_r && (state_r == S_HEAD) && (pend_idx_r == req_r)) begin
      my_t_nxt = cand;
    end

    // result register drains
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_ch.operation;
          req_nxt       = in_ch.requester;
          n_nxt         = n_cfg;
          issue_cnt_nxt = '0;
          best_t_nxt    = '0;
          best_v_nxt    = 1'b0;
          best_idx_nxt  = '0;
          my_t_nxt      = '0;
          status_nxt    = inactive ? ST_INACTIVE : ST_OK;
          if (inactive) begin
            state_nxt = S_HEAD;
          end else if (in_ch.operation == OP_REQUEST) begin
            state_nxt = S_MAX;
          end else if (in_ch.operation == OP_RELEASE) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_MAX: begin
        if (scan_done) begin
          issue_cnt_nxt = '0;
          state_nxt     = S_WRITE;
        end
      end
      S_WRITE: begin
        if (op_r == OP_REQUEST) begin
          if (best_t_r == '1) begin
            status_nxt = ST_EXHAUSTED;
          end else begin
            ram_we         = 1'b1;
            vld_nxt[req_r] = 1'b1;
          end
        end else begin
          vld_nxt[req_r] = 1'b0;
        end
        best_t_nxt   = '0;
        best_v_nxt   = 1'b0;
        best_idx_nxt = '0;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        if (scan_done) begin
          issue_cnt_nxt = '0;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          o_ticket_nxt  = (status_r == ST_INACTIVE) ? '0 : my_t_r;
          o_enter_nxt   = (status_r != ST_INACTIVE) && best_v_r && (best_idx_r == req_r);
          o_head_nxt    = best_v_r ? best_idx_r : '0;
          o_head_v_nxt  = best_v_r;
          o_status_nxt  = status_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= CFG_RESET;
      n_r         <= CNT_W'(1);
      issue_cnt_r <= '0;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    best_t_r   <= best_t_nxt;
    best_v_r   <= best_v_nxt;
    best_idx_r <= best_idx_nxt;
    my_t_r     <= my_t_nxt;
    pend_idx_r <= pend_idx_nxt;
    rd_vld_r   <= rd_vld_nxt;
    o_ticket_r <= o_ticket_nxt;
    o_enter_r  <= o_enter_nxt;
    o_head_r   <= o_head_nxt;
    o_head_v_r <= o_head_v_nxt;
    o_status_r <= o_status_nxt;
  end

  // result port
  assign out_ch.valid          = out_valid_r;
  assign out_ch.ticket         = o_ticket_r;
  assign out_ch.may_enter      = o_enter_r;
  assign out_ch.head_requester = o_head_r;
  assign out_ch.head_valid     = o_head_v_r;
  assign out_ch.status         = o_status_r;

  // checks
  `BTA_ASSERT_IMPL(a_issue_bound, scanning, issue_cnt_r <= n_r, "scan ran past active count")
  `BTA_ASSERT_IMPL(a_store_write, ram_we, (op_r == OP_REQUEST) && (best_t_r != '1), "bad store write")
  `BTA_ASSERT_NEXT(a_accept_busy, accept, !in_ch.ready, "item taken while busy")
  `BTA_ASSERT_IMPL(a_enter_head, out_ch.valid && out_ch.may_enter, out_ch.head_valid && (out_ch.ticket != '0), "enter without head")

endmodule

/* design/bta_ram.sv */
// ----------------------------------------------------------------------------
// bta_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter  int WIDTH = bta_pkg::DEF_TICKET_BITS,
  parameter  int DEPTH = bta_pkg::DEF_MAX_REQUESTERS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/bta_cmp.sv */
// ----------------------------------------------------------------------------
// bta_cmp
// shared ticket compare unit, one subtractor for both scan passes
// ----------------------------------------------------------------------------
module bta_cmp #(
  parameter int TICKET_BITS = bta_pkg::DEF_TICKET_BITS
) (
  input  bta_pkg::cmp_mode_t     mode,
  input  logic [TICKET_BITS-1:0] cand,
  input  logic [TICKET_BITS-1:0] best,
  input  logic                   best_v,
  output logic                   take
);
  import bta_pkg::*;

  logic [TICKET_BITS:0] diff;
  logic                 lt;
  logic                 eq;

  // cand - best, borrow means cand is lower
  assign diff = {1'b0, cand} - {1'b0, best};
  assign lt   = diff[TICKET_BITS];
  assign eq   = (diff[TICKET_BITS-1:0] == '0);

  // max pass keeps strictly larger, head pass keeps strictly lower nonzero
  always_comb begin
    unique case (mode)
      CMP_MAX: take = !lt && !eq;
      CMP_MIN: take = (cand != '0) && (!best_v || lt);
      default: take = 1'b0;
    endcase
  end

endmodule

/* verif/ticket_arbiter_checker.sv */
// ----------------------------------------------------------------------------
// ticket_arbiter_checker
// watches the access and result channels of the bakery ticket arbiter, keeps
// a shadow of the ticket store and the active count, predicts each result
// item and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module ticket_arbiter_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bta_pkg::CFG_W-1:0] cfg_wdata,
  bta_req_if                        acc_ch,
  bta_rsp_if                        res_ch,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam int NUM_REQ    = DEF_MAX_REQUESTERS;
  localparam int TOP_TICKET = (1 << DEF_TICKET_BITS) - 1;

  typedef struct packed {
    logic [DEF_TICKET_BITS-1:0] ticket;
    logic                       may_enter;
    logic [DEF_IDX_W-1:0]       head_requester;
    logic                       head_valid;
    status_t                    status;
  } reply_t;

  logic [DEF_TICKET_BITS-1:0] ticket_shadow [NUM_REQ];
  logic [CFG_W-1:0]           active_shadow;
  reply_t                     pending_replies [$];
  int                         fail_tally;

  // active count as the block uses it: zero counts as one, capped at the store size
  function automatic int live_count();
    int n = int'(active_shadow);
    if (n == 0) n = 1;
    if (n > NUM_REQ) n = NUM_REQ;
    return n;
  endfunction

  // apply one access to the shadow store and work out the reply
  function automatic reply_t serve_access(logic [1:0] op, logic [DEF_IDX_W-1:0] who);
    reply_t r;
    int     n;
    int     top;
    int     best;
    n = live_count();
    r = '0;
    r.status = ST_OK;
    if (int'(who) >= n) begin
      r.status = ST_INACTIVE;
    end else if (op == OP_REQUEST) begin
      top = 0;
      for (int i = 0; i < n; i++)
        if (int'(ticket_shadow[i]) > top) top = int'(ticket_shadow[i]);
      if (top >= TOP_TICKET) r.status = ST_EXHAUSTED;
      else ticket_shadow[who] = DEF_TICKET_BITS'(top + 1);
    end else if (op == OP_RELEASE) begin
      ticket_shadow[who] = '0;
    end
    // upward scan with strict compare, lower index wins a tie
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (ticket_shadow[i] != 0 && (!r.head_valid || int'(ticket_shadow[i]) < best)) begin
        r.head_valid     = 1'b1;
        r.head_requester = DEF_IDX_W'(i);
        best             = int'(ticket_shadow[i]);
      end
    end
    if (r.status != ST_INACTIVE) begin
      r.ticket    = ticket_shadow[who];
      r.may_enter = r.head_valid && (r.head_requester == who);
    end
    return r;
  endfunction

  // count a failure, show only the first few
  task automatic report_fault(string what, reply_t want, reply_t got);
    fail_tally++;
    if (fail_tally <= 10)
      $display("%t checker: %s exp tkt=%0d enter=%0b head=%0d hv=%0b st=%0d",
               $time, what, want.ticket, want.may_enter, want.head_requester,
               want.head_valid, want.status,
               " got tkt=%0d enter=%0b head=%0d hv=%0b st=%0d",
               got.ticket, got.may_enter, got.head_requester, got.head_valid, got.status);
  endtask

  // track config writes, predict on each accepted access, compare each result item
  always @(posedge clk) begin : track
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      foreach (ticket_shadow[i]) ticket_shadow[i] = '0;
      active_shadow = CFG_RESET;
      pending_replies.delete();
      fail_tally = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) active_shadow = cfg_wdata;
      if (acc_ch.valid && acc_ch.ready)
        pending_replies.push_back(serve_access(acc_ch.operation, acc_ch.requester));
      if (res_ch.valid && res_ch.ready) begin
        got.ticket         = res_ch.ticket;
        got.may_enter      = res_ch.may_enter;
        got.head_requester = res_ch.head_requester;
        got.head_valid     = res_ch.head_valid;
        got.status         = res_ch.status;
        if (pending_replies.size() == 0) begin
          report_fault("result item with no access pending", '0, got);
        end else begin
          want = pending_replies.pop_front();
          if (got.ticket !== want.ticket || got.may_enter !== want.may_enter ||
              got.head_requester !== want.head_requester ||
              got.head_valid !== want.head_valid || got.status !== want.status)
            report_fault("mismatch", want, got);
        end
      end
      fail_count  <= fail_tally;
      outstanding <= pending_replies.size();
    end
  end

endmodule

/* verif/bakery_ticket_arbiter_tb.sv */
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_tb
// drives access items in bursts with random gaps, stalls the result side on
// a rotating pattern, walks the active count through its extremes and lets
// the checker predict and compare every result item
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  typedef enum {MODE_MIXED, MODE_CLIMB, MODE_DRAIN, MODE_NOISE} phase_mode_t;

  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam int         ACCESS_TARGET  = 1650;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 50;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [CFG_W-1:0] cfg_wdata  = '0;
  logic             sink_ready = 1'b0;
  logic [15:0]      stall_mask = 16'hFFFF;
  int               mask_age   = 0;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               accesses_sent = 0;
  int               live_requesters = DEF_MAX_REQUESTERS;
  int               fail_count;
  int               outstanding;

  bta_req_if acc_ch ();
  bta_rsp_if res_ch ();

  assign res_ch.ready = sink_ready;

  bakery_ticket_arbiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (acc_ch),
    .out_ch    (res_ch)
  );

  ticket_arbiter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .acc_ch      (acc_ch),
    .res_ch      (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  always #1 clk = ~clk;

  // result side stalls on a rotating mask, re-picked now and then
  always @(negedge clk) begin
    if (mask_age == 0) begin
      mask_age   <= $urandom_range(24, 160);
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      mask_age   <= mask_age - 1;
      stall_mask <= {stall_mask[0], stall_mask[15:1]};
    end
    sink_ready <= stall_mask[0];
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (acc_ch.valid && acc_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one access item, with a random gap at the start of each burst
  task automatic send_access(input logic [1:0] op, input logic [2:0] who);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        acc_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    acc_ch.valid     <= 1'b1;
    acc_ch.operation <= op;
    acc_ch.requester <= who;
    @(posedge clk);
    while (!acc_ch.ready) @(posedge clk);
    burst_left--;
    accesses_sent++;
  endtask

  // drop valid and wait until every result item is back
  task automatic hold_until_drained();
    @(negedge clk);
    acc_ch.valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // active count write, only with the block idle
  task automatic write_active_count(input logic [CFG_W-1:0] value);
    hold_until_drained();
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    live_requesters = (value == 0) ? 1 : (value > DEF_MAX_REQUESTERS) ?
                      DEF_MAX_REQUESTERS : int'(value);
  endtask

  function automatic logic [CFG_W-1:0] pick_active_count();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd8;
      3:       return 4'd15;
      default: return CFG_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int req_pct, int rel_pct, int chk_pct);
    int r = $urandom_range(0, 99);
    if (r < req_pct) return OP_REQUEST;
    if (r < req_pct + rel_pct) return OP_RELEASE;
    if (r < req_pct + rel_pct + chk_pct) return OP_CHECK;
    return OP_SPARE;
  endfunction

  // mostly active requesters, some strays drawn from the full index range
  function automatic logic [2:0] pick_requester(int stray_pct);
    if ($urandom_range(0, 99) < stray_pct) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(0, live_requesters - 1));
  endfunction

  // stimulus
  initial begin
    int          phase_no;
    phase_mode_t mode;
    acc_ch.valid     = 1'b0;
    acc_ch.operation = OP_CHECK;
    acc_ch.requester = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, repeated request, spare opcode, idle release
    send_access(OP_CHECK, 3'd0);
    send_access(OP_REQUEST, 3'd0);
    send_access(OP_REQUEST, 3'd0);
    send_access(OP_REQUEST, 3'd7);
    send_access(OP_REQUEST, 3'd3);
    send_access(OP_SPARE, 3'd3);
    send_access(OP_RELEASE, 3'd0);
    send_access(OP_RELEASE, 3'd0);
    send_access(OP_REQUEST, 3'd5);
    // shrink: upper tickets hidden, upper indices inactive
    write_active_count(4'd3);
    send_access(OP_CHECK, 3'd7);
    send_access(OP_REQUEST, 3'd5);
    send_access(OP_REQUEST, 3'd2);
    send_access(OP_RELEASE, 3'd1);
    // zero acts as one requester
    write_active_count(4'd0);
    send_access(OP_CHECK, 3'd0);
    send_access(OP_REQUEST, 3'd1);
    send_access(OP_REQUEST, 3'd0);
    // above the store size saturates, hidden tickets come back, equal tickets tie
    write_active_count(4'd15);
    send_access(OP_CHECK, 3'd7);
    send_access(OP_CHECK, 3'd2);
    send_access(OP_RELEASE, 3'd0);
    send_access(OP_CHECK, 3'd3);
    send_access(OP_RELEASE, 3'd2);
    send_access(OP_RELEASE, 3'd3);
    send_access(OP_RELEASE, 3'd5);
    send_access(OP_RELEASE, 3'd7);

    // random phases, the first one climbs into ticket exhaustion
    phase_no = 0;
    while (accesses_sent < ACCESS_TARGET) begin
      hold_until_drained();
      if (phase_no == 0) begin
        mode = MODE_CLIMB;
      end else begin
        case ($urandom_range(0, 5))
          3:       mode = MODE_CLIMB;
          4:       mode = MODE_DRAIN;
          5:       mode = MODE_NOISE;
          default: mode = MODE_MIXED;
        endcase
      end
      if (mode == MODE_DRAIN) write_active_count(4'd15);
      else if ($urandom_range(0, 2) != 0) write_active_count(pick_active_count());
      case (mode)
        MODE_CLIMB: begin
          repeat ($urandom_range(260, 340)) send_access(pick_op(95, 2, 2), pick_requester(5));
        end
        MODE_DRAIN: begin
          for (int i = 0; i < DEF_MAX_REQUESTERS; i++) send_access(OP_RELEASE, 3'(i));
          repeat ($urandom_range(20, 80)) send_access(pick_op(50, 30, 15), pick_requester(10));
        end
        MODE_NOISE: begin
          repeat ($urandom_range(20, 60)) send_access(pick_op(30, 20, 20), pick_requester(50));
        end
        default: begin
          repeat ($urandom_range(30, 120)) send_access(pick_op(50, 30, 15), pick_requester(10));
        end
      endcase
      phase_no++;
    end

    // let everything come back, then give the verdict
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
